// ===== rtl/rgbfade_pkg.sv =====
// Types and constants shared by the RGB565 fade sequencer.
// Holds command codes, queue word layout, config register map and phase codes.
// No dependencies.
package rgbfade_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLASH_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TARGET = 2'd2;

    localparam logic [31:0] SPLASH_MS_RST   = 32'd5000;
    localparam logic [15:0] FADE_MS_RST     = 16'd600;
    localparam logic [15:0] FADE_TARGET_RST = 16'h0000;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_UPDATE  = 2'd1;
    localparam logic [1:0] CMD_PIXEL   = 2'd2;

    localparam logic [7:0] LEVEL_FULL = 8'hFF;

    typedef enum logic [1:0] {
        PH_SPLASH = 2'd0,
        PH_FADE   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_UPDATE,
        OP_PIXEL,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_WRITE
    } t_bstate;

    typedef struct packed {
        t_op         op;
        logic [31:0] arg;
    } t_qitem;

    typedef struct packed {
        logic [31:0] splash_ms;
        logic [15:0] fade_ms;
        logic [15:0] fade_target;
    } t_cfg;

endpackage

// ===== rtl/rgbfade_ifs.sv =====
// Valid/ready channel interfaces for the RGB565 fade sequencer.
// Input word, result word and config write channels; uses rgbfade_pkg widths.
interface rgbfade_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [15:0] pixel_in;

    modport source (output valid, command, now_ms, pixel_in, input ready);
    modport sink   (input valid, command, now_ms, pixel_in, output ready);
endinterface

interface rgbfade_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_out;
    logic [1:0]  phase;
    logic        finished;
    logic [7:0]  fade_level_out;

    modport source (output valid, pixel_out, phase, finished, fade_level_out, input ready);
    modport sink   (input valid, pixel_out, phase, finished, fade_level_out, output ready);
endinterface

interface rgbfade_cfg_if;
    import rgbfade_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rgbfade_front.sv =====
// Front end: accepts input words, classifies the command and queues them.
// Depends on rgbfade_pkg and rgbfade_in_if.
module rgbfade_front
    import rgbfade_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbfade_in_if.sink    i_in,
    output t_qitem        o_item,
    output logic          o_item_valid,
    input  logic          i_pop
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qitem          r_mem [DEPTH];
    logic [IW-1:0]   r_wr, n_wr;
    logic [IW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    t_qitem          w_item;
    logic            w_push;

    always_comb begin
        w_item.arg = i_in.now_ms;
        case (i_in.command)
            CMD_RESTART: w_item.op = OP_RESTART;
            CMD_UPDATE:  w_item.op = OP_UPDATE;
            CMD_PIXEL: begin
                w_item.op  = OP_PIXEL;
                w_item.arg = {16'h0000, i_in.pixel_in};
            end
            default:     w_item.op = OP_NOP;
        endcase
    end

    assign i_in.ready   = (r_cnt != CW'(DEPTH));
    assign w_push       = i_in.valid & i_in.ready;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/rgbfade_back.sv =====
// Back end: phase sequencer, restoring level divider, pixel mixer, result register.
// Depends on rgbfade_pkg and rgbfade_out_if.
module rgbfade_back
    import rgbfade_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qitem        i_item,
    input  logic          i_item_valid,
    output logic          o_pop,
    input  t_cfg          i_cfg,
    rgbfade_out_if.source o_out
);

    function automatic logic [5:0] mix_ch(logic [5:0] a, logic [5:0] b, logic [7:0] lvl);
        logic [5:0]  d;
        logic [13:0] p;
        logic [13:0] q;
        d = (b >= a) ? (b - a) : (a - b);
        p = d * lvl;
        q = (p + 14'd1 + {8'h00, p[13:8]}) >> 8;
        return (b >= a) ? (a + q[5:0]) : (a - q[5:0]);
    endfunction

    function automatic logic [15:0] mix_px(logic [15:0] px, logic [15:0] tg, logic [7:0] lvl);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] b;
        r = mix_ch({1'b0, px[15:11]}, {1'b0, tg[15:11]}, lvl);
        g = mix_ch(px[10:5], tg[10:5], lvl);
        b = mix_ch({1'b0, px[4:0]}, {1'b0, tg[4:0]}, lvl);
        return {r[4:0], g, b[4:0]};
    endfunction

    t_bstate      r_st, n_st;
    t_phase       r_phase, n_phase;
    logic [31:0]  r_start, n_start;
    logic [7:0]   r_level, n_level;
    logic [23:0]  r_rem, n_rem;
    logic [7:0]   r_quo, n_quo;
    logic [2:0]   r_step, n_step;
    logic         r_out_valid, n_out_valid;
    logic [15:0]  r_pix, n_pix;
    logic         w_out_free;
    logic         w_take;
    logic [31:0]  w_elapsed;
    logic         w_fade_end;
    logic         w_div_start;
    logic         w_load;
    logic [23:0]  w_dshift;

    assign w_out_free  = !r_out_valid | o_out.ready;
    assign w_take      = (r_st == BS_IDLE) & i_item_valid & w_out_free;
    assign w_elapsed   = i_item.arg - r_start;
    assign w_fade_end  = (w_elapsed >= {16'h0000, i_cfg.fade_ms});
    assign w_div_start = w_take & (i_item.op == OP_UPDATE) & (r_phase == PH_FADE) & !w_fade_end;
    assign w_dshift    = {8'h00, i_cfg.fade_ms} << r_step;
    assign o_pop       = w_take;

    always_comb begin
        n_st = r_st;
        case (r_st)
            BS_IDLE:  if (w_div_start) n_st = BS_DIV;
            BS_DIV:   if (r_step == 3'd0) n_st = BS_WRITE;
            BS_WRITE: if (w_out_free) n_st = BS_IDLE;
            default:  n_st = BS_IDLE;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_level = r_level;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_step  = r_step;
        n_pix   = r_pix;
        w_load  = 1'b0;
        case (r_st)
            BS_IDLE: begin
                if (w_take) begin
                    w_load = !w_div_start;
                    n_pix  = 16'h0000;
                    case (i_item.op)
                        OP_RESTART: begin
                            n_phase = PH_SPLASH;
                            n_start = i_item.arg;
                            n_level = '0;
                        end
                        OP_UPDATE: begin
                            if (r_phase == PH_SPLASH) begin
                                if (w_elapsed >= i_cfg.splash_ms) begin
                                    n_phase = PH_FADE;
                                    n_start = i_item.arg;
                                    n_level = '0;
                                end
                            end else if (r_phase == PH_FADE) begin
                                if (w_fade_end) begin
                                    n_phase = PH_DONE;
                                    n_level = LEVEL_FULL;
                                end else begin
                                    n_rem  = {w_elapsed[15:0], 8'h00} -
                                             {8'h00, w_elapsed[15:0]};
                                    n_quo  = '0;
                                    n_step = 3'd7;
                                end
                            end
                        end
                        OP_PIXEL: begin
                            n_pix = (r_phase == PH_FADE) ?
                                    mix_px(i_item.arg[15:0], i_cfg.fade_target, r_level) :
                                    i_item.arg[15:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_DIV: begin
                if (r_rem >= w_dshift) begin
                    n_rem         = r_rem - w_dshift;
                    n_quo[r_step] = 1'b1;
                end
                n_step = r_step - 3'd1;
            end
            BS_WRITE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_level = r_quo;
                    n_pix   = 16'h0000;
                end
            end
            default: begin
            end
        endcase
        n_out_valid = w_load | (r_out_valid & !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BS_IDLE;
            r_phase     <= PH_SPLASH;
            r_start     <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
        if (w_load) begin
            r_pix <= n_pix;
        end
    end

    logic [1:0]  r_oph;
    logic [7:0]  r_olvl;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oph  <= n_phase;
            r_olvl <= n_level;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pixel_out      = r_pix;
    assign o_out.phase          = r_oph;
    assign o_out.finished       = (r_oph == PH_DONE);
    assign o_out.fade_level_out = r_olvl;

endmodule

// ===== rtl/timed_rgb565_fade_sequencer.sv =====
// Top level of the RGB565 fade sequencer: config registers, front queue, back end.
// Depends on rgbfade_pkg, rgbfade_ifs, rgbfade_front and rgbfade_back.
//
// One result word per input word, in order. Restart, pixel and unused-command
// words, and updates that do not stay inside the fade, are handled in the cycle
// that takes them; a time update that stays inside the fade holds the back end
// through the cycle that takes it, 8 steps of the restoring divider for the fade
// level, and the result write, which waits for a free result register. A queue of
// QUEUE_DEPTH words sits between input and back end; the back end takes the next
// word only when the result register is empty or is read in that same cycle.
// Config writes are always ready and take effect on the next cycle.
module timed_rgb565_fade_sequencer
    import rgbfade_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgbfade_in_if.sink    i_in,
    rgbfade_cfg_if.sink   i_cfg,
    rgbfade_out_if.source o_out
);

    t_cfg    r_cfg;
    t_qitem  w_item;
    logic    w_item_valid;
    logic    w_pop;
    logic    w_cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.splash_ms   <= SPLASH_MS_RST;
            r_cfg.fade_ms     <= FADE_MS_RST;
            r_cfg.fade_target <= FADE_TARGET_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg.index)
                CFG_SPLASH_MS:   r_cfg.splash_ms   <= i_cfg.data;
                CFG_FADE_MS:     r_cfg.fade_ms     <= i_cfg.data[15:0];
                CFG_FADE_TARGET: r_cfg.fade_target <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    rgbfade_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    rgbfade_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .i_cfg        (r_cfg),
        .o_out        (o_out)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("queue popped while empty");

    a_done_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.finished) |-> (o_out.fade_level_out == LEVEL_FULL))
        else $error("done phase without full fade level");

    a_splash_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.phase == PH_SPLASH) |-> (o_out.fade_level_out == 8'h00))
        else $error("splash phase with nonzero fade level");

endmodule

// ===== bench/fade_sequencer_checker.sv =====
// Result checker for the timed RGB565 fade sequencer: watches the input, config and result channels.
// Keeps its own phase/level predictor and compares every result word field by field.
// Depends on rgbfade_pkg and the channel interfaces in rgbfade_ifs.
`timescale 1ns / 1ps

module fade_sequencer_checker
    import rgbfade_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgbfade_in_if        i_in,
    rgbfade_cfg_if       i_cfg,
    rgbfade_out_if       i_res,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked,
    output int           o_fade_pixels
);

    typedef struct packed {
        logic [15:0] pixel;
        t_phase      phase;
        logic        finished;
        logic [7:0]  level;
    } t_fade_result;

    t_fade_result predicted_words[$];

    logic [31:0] cfg_splash;
    logic [15:0] cfg_fade;
    logic [15:0] cfg_target;
    t_phase      seq_phase;
    logic [31:0] seq_start;
    logic [7:0]  seq_level;
    int          mismatches;
    int          checked;
    int          fade_pixels;

    assign o_fail_count  = mismatches;
    assign o_checked     = checked;
    assign o_fade_pixels = fade_pixels;

    function automatic logic [5:0] blend_channel(input logic [5:0] a, input logic [5:0] b,
                                                 input logic [7:0] lvl);
        logic [13:0] span;
        if (b >= a) begin
            span = (b - a) * lvl;
            return a + 6'(span / LEVEL_FULL);
        end
        span = (a - b) * lvl;
        return a - 6'(span / LEVEL_FULL);
    endfunction

    function automatic logic [15:0] blend_pixel(input logic [15:0] px, input logic [15:0] tgt,
                                                input logic [7:0] lvl);
        logic [5:0] red;
        logic [5:0] grn;
        logic [5:0] blu;
        red = blend_channel({1'b0, px[15:11]}, {1'b0, tgt[15:11]}, lvl);
        grn = blend_channel(px[10:5], tgt[10:5], lvl);
        blu = blend_channel({1'b0, px[4:0]}, {1'b0, tgt[4:0]}, lvl);
        return {red[4:0], grn, blu[4:0]};
    endfunction

    function automatic t_fade_result step_sequencer(input logic [1:0] cmd,
                                                    input logic [31:0] now,
                                                    input logic [15:0] px);
        t_fade_result res;
        logic [31:0]  elapsed;
        elapsed   = now - seq_start;
        res.pixel = '0;
        case (cmd)
            CMD_RESTART: begin
                seq_phase = PH_SPLASH;
                seq_start = now;
                seq_level = '0;
            end
            CMD_UPDATE: begin
                if (seq_phase == PH_SPLASH) begin
                    if (elapsed >= cfg_splash) begin
                        seq_phase = PH_FADE;
                        seq_start = now;
                        seq_level = '0;
                    end
                end else if (seq_phase == PH_FADE) begin
                    if (elapsed >= {16'd0, cfg_fade}) begin
                        seq_level = LEVEL_FULL;
                        seq_phase = PH_DONE;
                    end else begin
                        seq_level = 8'((64'(elapsed) * 64'(LEVEL_FULL)) / cfg_fade);
                    end
                end
            end
            CMD_PIXEL: begin
                if (seq_phase == PH_FADE) begin
                    res.pixel = blend_pixel(px, cfg_target, seq_level);
                    fade_pixels++;
                end else begin
                    res.pixel = px;
                end
            end
            default: ;
        endcase
        res.phase    = seq_phase;
        res.finished = (seq_phase == PH_DONE);
        res.level    = seq_level;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fade_result want;
        if (!i_rst_n) begin
            cfg_splash = SPLASH_MS_RST;
            cfg_fade   = FADE_MS_RST;
            cfg_target = FADE_TARGET_RST;
            seq_phase  = PH_SPLASH;
            seq_start  = '0;
            seq_level  = '0;
            predicted_words.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (predicted_words.size() == 0) begin
                    $error("result word 0x%0h arrived with no prediction pending",
                           i_res.pixel_out);
                    mismatches++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("pixel_out", want.pixel, i_res.pixel_out);
                    check_field("phase", want.phase, i_res.phase);
                    check_field("finished", want.finished, i_res.finished);
                    check_field("fade_level_out", want.level, i_res.fade_level_out);
                    checked++;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SPLASH_MS:   cfg_splash = i_cfg.data;
                    CFG_FADE_MS:     cfg_fade   = i_cfg.data[15:0];
                    CFG_FADE_TARGET: cfg_target = i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                predicted_words.push_back(step_sequencer(i_in.command, i_in.now_ms,
                                                         i_in.pixel_in));
            end
        end
        o_pending = predicted_words.size();
    end

endmodule

// ===== bench/timed_rgb565_fade_sequencer_tb.sv =====
// Testbench top for the timed RGB565 fade sequencer: clock, reset, stimulus and verdict.
// Drives restart/update/pixel words and register writes; fade_sequencer_checker does the compare.
// Depends on rgbfade_pkg, rgbfade_ifs, the DUT and fade_sequencer_checker.
`timescale 1ns / 1ps

module timed_rgb565_fade_sequencer_tb;
    import rgbfade_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         PHASE_WORDS = 325;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   items_sent;
    int   settings_used;
    int   cycle_count;
    int   fail_count;
    int   pending;
    int   checked;
    int   fade_pixels;

    rgbfade_in_if  in_ch ();
    rgbfade_cfg_if cfg_ch ();
    rgbfade_out_if out_ch ();

    timed_rgb565_fade_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    fade_sequencer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_cfg         (cfg_ch),
        .i_res         (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_fade_pixels (fade_pixels)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_offset(input logic [31:0] span);
        if ($urandom_range(0, 3) == 0) begin
            return span - 1;
        end
        return $urandom_range(0, span - 1);
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [31:0] now,
                             input logic [15:0] px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.command  <= cmd;
        in_ch.now_ms   <= now;
        in_ch.pixel_in <= px;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_pixel_burst();
        repeat ($urandom_range(0, 4)) send_word(CMD_PIXEL, $urandom(), pick_pixel());
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] splash, input logic [15:0] fade,
                                 input logic [15:0] color);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        write_reg(CFG_SPLASH_MS, splash);
        write_reg(CFG_FADE_MS, {16'($urandom()), fade});
        write_reg(CFG_FADE_TARGET, {16'($urandom()), color});
        write_reg(CFG_UNUSED, $urandom());
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // restart, hold the splash, cross into the fade, sweep the level, finish; may stop short
    task automatic play_fade_run(input logic [31:0] splash, input logic [15:0] fade);
        logic [31:0] base;
        logic [31:0] fade_start;
        logic [31:0] step;
        base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 64) : $urandom();
        send_word(CMD_RESTART, base, pick_pixel());
        send_pixel_burst();
        if (splash != 0) begin
            repeat ($urandom_range(0, 2)) begin
                send_word(CMD_UPDATE, base + pick_offset(splash), pick_pixel());
                send_pixel_burst();
            end
        end
        if ($urandom_range(0, 9) == 0) return;
        step = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(1, 5));
        if (32'hFFFF_FFFF - splash < step) step = 32'hFFFF_FFFF - splash;
        fade_start = base + splash + step;
        send_word(CMD_UPDATE, fade_start, pick_pixel());
        send_pixel_burst();
        if (fade != 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_word(CMD_UPDATE, fade_start + pick_offset({16'd0, fade}), pick_pixel());
                send_pixel_burst();
            end
        end
        if ($urandom_range(0, 9) == 0) return;
        send_word(CMD_UPDATE, fade_start + fade + $urandom_range(0, 3), pick_pixel());
        send_pixel_burst();
        if ($urandom_range(0, 1) == 0) begin
            send_word(CMD_UPDATE, $urandom(), pick_pixel());
            send_pixel_burst();
        end
    endtask

    task automatic run_random_phase(input logic [31:0] splash, input logic [15:0] fade,
                                    input logic [15:0] color);
        int stop_at;
        apply_setting(splash, fade, color);
        stop_at = items_sent + PHASE_WORDS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(2'($urandom_range(0, 3)), $urandom(), pick_pixel());
            end else begin
                play_fade_run(splash, fade);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.command  = CMD_RESTART;
        in_ch.now_ms   = '0;
        in_ch.pixel_in = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_SPLASH_MS;
        cfg_ch.data    = '0;
        src_idle_pct   = 12;
        sink_idle_pct  = 73;
        items_sent     = 0;
        settings_used  = 0;
        cycle_count    = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset durations: splash 5000, fade 600, target black
        send_word(CMD_PIXEL, 32'h0, 16'hFFFF);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(CMD_UPDATE, 32'd4999, 16'h0);
        send_word(CMD_UPDATE, 32'd5000, 16'h0);
        send_word(CMD_PIXEL, 32'h0, 16'hFFFF);
        send_word(CMD_UPDATE, 32'd5300, 16'hFFFF);
        send_word(CMD_PIXEL, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(CMD_PIXEL, 32'h0, 16'h0000);
        send_word(CMD_UPDATE, 32'd5599, 16'h0);
        send_word(CMD_UPDATE, 32'd5600, 16'h0);
        send_word(CMD_PIXEL, 32'h0, 16'h1234);
        send_word(CMD_UPDATE, 32'd9999, 16'h0);
        send_word(CMD_RESTART, 32'hFFFF_FF00, 16'hFFFF);

        // wrap the elapsed time, then a zero fade duration
        apply_setting(32'h10, 16'd0, 16'hFFFF);
        send_word(CMD_UPDATE, 32'h10, 16'h0);
        send_word(CMD_PIXEL, 32'h0, 16'h0000);
        send_word(CMD_UPDATE, 32'h20, 16'h0);
        send_word(CMD_UNUSED, 32'h0, 16'h0);

        // zero splash, longest fade
        apply_setting(32'h0, 16'hFFFF, 16'hF81F);
        send_word(CMD_RESTART, 32'h0, 16'h0);
        send_word(CMD_UPDATE, 32'h0, 16'h0);
        send_word(CMD_UPDATE, 32'd65534, 16'h0);
        send_word(CMD_PIXEL, 32'h0, 16'h07E0);
        send_word(CMD_PIXEL, 32'h0, 16'hF81F);
        send_word(CMD_UPDATE, 32'd65535, 16'h0);

        run_random_phase(32'd12, 16'd30, 16'($urandom()));
        run_random_phase(32'd0, 16'd1, 16'hFFFF);
        src_idle_pct  = 73;
        sink_idle_pct = 12;
        run_random_phase(32'hFFFF_FFFF, 16'd200, 16'h0000);
        run_random_phase(32'd100, 16'hFFFF, 16'($urandom()));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random_phase(32'($urandom_range(0, 50)), 16'd0, 16'($urandom()));
        run_random_phase(32'($urandom_range(1, 200)), 16'($urandom_range(1, 900)),
                         16'($urandom()));

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Drove %0d input words through splash, fade and done under %0d register settings.",
                 items_sent, settings_used);
        $display("Checked %0d result words, %0d of them pixels blended mid-fade.",
                 checked, fade_pixels);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rgbfade_pkg.sv
rtl/rgbfade_ifs.sv
rtl/rgbfade_front.sv
rtl/rgbfade_back.sv
rtl/timed_rgb565_fade_sequencer.sv
bench/fade_sequencer_checker.sv
bench/timed_rgb565_fade_sequencer_tb.sv
